// ----- design/afa_pkg.sv -----
// Shared types and flag constants for the accumulator and flag ALU.
`default_nettype none
package afa_pkg;

    typedef enum logic [3:0] {
        KIND_DAA  = 4'd0,
        KIND_RLCA = 4'd1,
        KIND_RRCA = 4'd2,
        KIND_RLA  = 4'd3,
        KIND_RRA  = 4'd4,
        KIND_CPL  = 4'd5,
        KIND_SCF  = 4'd6,
        KIND_CCF  = 4'd7,
        KIND_NEG  = 4'd8,
        KIND_CP   = 4'd9
    } kind_t;

    // Flag bit positions: S Z Y H X P N C
    localparam int unsigned FS = 7;
    localparam int unsigned FZ = 6;
    localparam int unsigned FY = 5;
    localparam int unsigned FH = 4;
    localparam int unsigned FX = 3;
    localparam int unsigned FP = 2;
    localparam int unsigned FN = 1;
    localparam int unsigned FC = 0;

    localparam logic [7:0] MASK_YX     = 8'h28;
    localparam logic [7:0] MASK_SZP    = 8'hC4;
    localparam logic [7:0] DAA_LIMIT   = 8'h99;
    localparam logic [7:0] DAA_ADJ_LO  = 8'h06;
    localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
    localparam logic [3:0] DAA_DIGIT   = 4'h9;
    localparam logic [7:0] NEG_MIN     = 8'h80;

    // Item in flight after the adder stage
    typedef struct packed {
        kind_t      kind;
        logic [7:0] acc;
        logic [7:0] flags;
        logic [7:0] q;
        logic [7:0] operand;
        logic       daa_hi;   // accumulator above 0x99
        logic [8:0] sum;      // 9-bit add/subtract result
    } work_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] flags;
    } result_t;

endpackage
`default_nettype wire

// ----- design/afa_flag_calc.sv -----
// Result accumulator and flag byte from the adder output of one item.
`default_nettype none
module afa_flag_calc (
    input  afa_pkg::work_t   work,
    output afa_pkg::result_t result
);
    import afa_pkg::*;

    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] keep;
    logic [7:0] res;
    logic [7:0] ra;
    logic [7:0] rf;
    logic       zero;
    logic       par;

    always_comb
    begin
        a    = work.acc;
        f    = work.flags;
        keep = f & MASK_SZP;
        res  = work.sum[7:0];
        zero = (res == 8'h00);
        par  = ~^res;
        ra   = a;
        rf   = f;
        case (work.kind)
            KIND_DAA:
            begin
                ra = res;
                rf = (f & 8'h03) | (res & 8'hA8);
                rf[FC] = f[FC] | work.daa_hi;
                rf[FH] = a[4] ^ res[4];
                rf[FZ] = zero;
                rf[FP] = par;
            end
            KIND_RLCA:
            begin
                ra = {a[6:0], a[7]};
                rf = keep | (ra & MASK_YX);
                rf[FC] = a[7];
            end
            KIND_RRCA:
            begin
                ra = {a[0], a[7:1]};
                rf = keep | (ra & MASK_YX);
                rf[FC] = a[0];
            end
            KIND_RLA:
            begin
                ra = {a[6:0], f[FC]};
                rf = keep | (ra & MASK_YX);
                rf[FC] = a[7];
            end
            KIND_RRA:
            begin
                ra = {f[FC], a[7:1]};
                rf = keep | (ra & MASK_YX);
                rf[FC] = a[0];
            end
            KIND_CPL:
            begin
                ra = ~a;
                rf = (f & 8'hC5) | (ra & MASK_YX);
                rf[FH] = 1'b1;
                rf[FN] = 1'b1;
            end
            KIND_SCF:
            begin
                rf = keep | (((work.q ^ f) | a) & MASK_YX);
                rf[FC] = 1'b1;
            end
            KIND_CCF:
            begin
                rf = keep | (((work.q ^ f) | a) & MASK_YX);
                rf[FH] = f[FC];
                rf[FC] = ~f[FC];
            end
            KIND_NEG:
            begin
                ra = res;
                rf = res & 8'hA8;
                rf[FN] = 1'b1;
                rf[FZ] = zero;
                rf[FC] = (a != 8'h00);
                rf[FP] = (a == NEG_MIN);
                rf[FH] = a[4] ^ res[4];
            end
            KIND_CP:
            begin
                rf = (res & 8'h80) | (work.operand & MASK_YX);
                rf[FN] = 1'b1;
                rf[FZ] = zero;
                rf[FC] = work.sum[8];
                rf[FH] = a[4] ^ res[4] ^ work.operand[4];
                rf[FP] = (a[7] ^ work.operand[7]) & (a[7] ^ res[7]);
            end
            default:
            begin
                ra = a;
                rf = f;
            end
        endcase
        result.acc   = ra;
        result.flags = rf;
    end

endmodule
`default_nettype wire

// ----- design/accumulator_flag_alu.sv -----
// Top level: three-stage accumulator and flag ALU with valid/ready channels.
// Throughput: one beat per cycle while out_ready is high; the stages are decode/adjust,
// add/subtract, flag build, each with its own valid bit, and a stall holds each full stage up to the first empty one.
// Reset: rst_n clears all stage valid bits asynchronously; payload is unreset.
`default_nettype none
module accumulator_flag_alu (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [3:0] kind,
    input  wire logic [7:0] acc_in,
    input  wire logic [7:0] flags_in,
    input  wire logic [7:0] q_in,
    input  wire logic [7:0] operand,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      acc_out,
    output logic [7:0]      flags_out,
    output logic [7:0]      q_out
);
    import afa_pkg::*;

    // Stage 1: decoded operands for the adder
    logic       s1_valid_reg;
    kind_t      s1_kind_reg;
    logic [7:0] s1_acc_reg;
    logic [7:0] s1_flags_reg;
    logic [7:0] s1_q_reg;
    logic [7:0] s1_operand_reg;
    logic       s1_daa_hi_reg;
    logic [7:0] s1_x_reg;
    logic [7:0] s1_y_reg;
    logic       s1_sub_reg;

    // Stage 2: adder result
    logic       s2_valid_reg;
    work_t      s2_work_reg;
    work_t      s2_work_next;

    // Stage 3: output
    logic       s3_valid_reg;
    result_t    s3_result_reg;
    result_t    s3_result_next;

    logic       s1_ready;
    logic       s2_ready;
    logic       s3_ready;

    kind_t      kind_dec;
    logic       daa_hi;
    logic [7:0] x_next;
    logic [7:0] y_next;
    logic       sub_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Pick adder operands per kind
    always_comb
    begin
        kind_dec = kind_t'(kind);
        daa_hi   = (acc_in > DAA_LIMIT);
        x_next   = acc_in;
        y_next   = 8'h00;
        sub_next = 1'b0;
        case (kind_dec)
            KIND_DAA:
            begin
                if (flags_in[FH] || (acc_in[3:0] > DAA_DIGIT))
                begin
                    y_next = y_next | DAA_ADJ_LO;
                end
                if (flags_in[FC] || daa_hi)
                begin
                    y_next = y_next | DAA_ADJ_HI;
                end
                sub_next = flags_in[FN];
            end
            KIND_NEG:
            begin
                x_next   = 8'h00;
                y_next   = acc_in;
                sub_next = 1'b1;
            end
            KIND_CP:
            begin
                y_next   = operand;
                sub_next = 1'b1;
            end
            default:
            begin
                sub_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        s2_work_next.kind    = s1_kind_reg;
        s2_work_next.acc     = s1_acc_reg;
        s2_work_next.flags   = s1_flags_reg;
        s2_work_next.q       = s1_q_reg;
        s2_work_next.operand = s1_operand_reg;
        s2_work_next.daa_hi  = s1_daa_hi_reg;
        if (s1_sub_reg)
        begin
            s2_work_next.sum = {1'b0, s1_x_reg} - {1'b0, s1_y_reg};
        end
        else
        begin
            s2_work_next.sum = {1'b0, s1_x_reg} + {1'b0, s1_y_reg};
        end
    end

    afa_flag_calc u_flag_calc (
        .work   (s2_work_reg),
        .result (s3_result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_kind_reg    <= kind_dec;
            s1_acc_reg     <= acc_in;
            s1_flags_reg   <= flags_in;
            s1_q_reg       <= q_in;
            s1_operand_reg <= operand;
            s1_daa_hi_reg  <= daa_hi;
            s1_x_reg       <= x_next;
            s1_y_reg       <= y_next;
            s1_sub_reg     <= sub_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_work_reg <= s2_work_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_result_reg <= s3_result_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign acc_out   = s3_result_reg.acc;
    assign flags_out = s3_result_reg.flags;
    assign q_out     = s3_result_reg.flags;

endmodule
`default_nettype wire

// ----- design/afa_checker.sv -----
// Port-level checks for the accumulator and flag ALU, bound to the top level.
`default_nettype none
module afa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] acc_out,
    input wire logic [7:0] flags_out,
    input wire logic [7:0] q_out
);

    // Q always mirrors the flags of the beat on the output
    a_q_eq_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (q_out == flags_out))
        else $error("q_out differs from flags_out");

    // An empty output stage frees the whole pipe
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output stage");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(acc_out) && $stable(flags_out)))
        else $error("output payload changed while stalled");

endmodule

bind accumulator_flag_alu afa_checker u_afa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .acc_out   (acc_out),
    .flags_out (flags_out),
    .q_out     (q_out)
);
`default_nettype wire

// ----- verif/accumulator_flag_alu_test.sv -----
// Self-checking testbench for the accumulator and flag ALU: directed and random beats.
`default_nettype none
module accumulator_flag_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    import afa_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned RANDOM_PER_PHASE = 94;

    localparam logic [7:0] FLAG_S = 8'h1 << FS;
    localparam logic [7:0] FLAG_Z = 8'h1 << FZ;
    localparam logic [7:0] FLAG_H = 8'h1 << FH;
    localparam logic [7:0] FLAG_P = 8'h1 << FP;
    localparam logic [7:0] FLAG_N = 8'h1 << FN;
    localparam logic [7:0] FLAG_C = 8'h1 << FC;

    class alu_scoreboard;
        typedef struct {
            logic [7:0] acc;
            logic [7:0] flags;
        } alu_result_t;

        alu_result_t pending[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // S, Z, Y, X and even parity of an 8-bit result
        function logic [7:0] sign_zero_parity(input logic [7:0] v);
            return (v & (FLAG_S | MASK_YX)) | ((v == 8'h00) ? FLAG_Z : 8'h00) |
                   ((~^v) ? FLAG_P : 8'h00);
        endfunction

        function void compute_result(input logic [3:0] k, input logic [7:0] a,
                                     input logic [7:0] f, input logic [7:0] q,
                                     input logic [7:0] d, output logic [7:0] ra,
                                     output logic [7:0] rf);
            logic [7:0] keep;
            logic [7:0] adj;
            logic [7:0] res;
            logic [8:0] diff;
            keep = f & MASK_SZP;
            ra = a;
            rf = f;
            case (k)
                KIND_DAA:
                begin
                    adj = 8'h00;
                    if (f[FH] || a[3:0] > DAA_DIGIT) adj |= DAA_ADJ_LO;
                    if (f[FC] || a > DAA_LIMIT) adj |= DAA_ADJ_HI;
                    res = f[FN] ? (a - adj) : (a + adj);
                    rf = (f & (FLAG_C | FLAG_N)) | ((a > DAA_LIMIT) ? FLAG_C : 8'h00) |
                         ((a ^ res) & FLAG_H) | sign_zero_parity(res);
                    ra = res;
                end
                KIND_RLCA:
                begin
                    ra = {a[6:0], a[7]};
                    rf = keep | (ra & MASK_YX) | {7'd0, a[7]};
                end
                KIND_RRCA:
                begin
                    ra = {a[0], a[7:1]};
                    rf = keep | (ra & MASK_YX) | {7'd0, a[0]};
                end
                KIND_RLA:
                begin
                    ra = {a[6:0], f[FC]};
                    rf = keep | (ra & MASK_YX) | {7'd0, a[7]};
                end
                KIND_RRA:
                begin
                    ra = {f[FC], a[7:1]};
                    rf = keep | (ra & MASK_YX) | {7'd0, a[0]};
                end
                KIND_CPL:
                begin
                    ra = ~a;
                    rf = (f & (MASK_SZP | FLAG_C)) | (ra & MASK_YX) | FLAG_H | FLAG_N;
                end
                KIND_SCF:
                    rf = keep | (((q ^ f) | a) & MASK_YX) | FLAG_C;
                KIND_CCF:
                    rf = keep | (((q ^ f) | a) & MASK_YX) | (f[FC] ? FLAG_H : FLAG_C);
                KIND_NEG:
                begin
                    res = 8'h00 - a;
                    ra = res;
                    rf = FLAG_N | ((res == 8'h00) ? FLAG_Z : 8'h00) | (res & FLAG_S) |
                         ((a != 8'h00) ? FLAG_C : 8'h00) | ((a == NEG_MIN) ? FLAG_P : 8'h00) |
                         ((a ^ res) & FLAG_H) | (res & MASK_YX);
                end
                KIND_CP:
                begin
                    diff = {1'b0, a} - {1'b0, d};
                    res = diff[7:0];
                    rf = FLAG_N | ((res == 8'h00) ? FLAG_Z : 8'h00) | (res & FLAG_S) |
                         {7'd0, diff[8]} | ((a ^ res ^ d) & FLAG_H) | (d & MASK_YX);
                    if ((a[7] ^ d[7]) && (a[7] ^ res[7])) rf |= FLAG_P;
                end
                default:
                begin
                    // unused codes pass accumulator and flags through
                end
            endcase
        endfunction

        function void note_input(input logic [3:0] k, input logic [7:0] a,
                                 input logic [7:0] f, input logic [7:0] q,
                                 input logic [7:0] d);
            alu_result_t r;
            compute_result(k, a, f, q, d, r.acc, r.flags);
            pending.push_back(r);
        endfunction

        function void check_output(input logic [7:0] acc, input logic [7:0] flags,
                                   input logic [7:0] q);
            alu_result_t r;
            if (pending.size() == 0)
            begin
                $error("output beat with nothing expected: acc_out=%h flags_out=%h q_out=%h",
                       acc, flags, q);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (acc !== r.acc)
            begin
                $error("acc_out mismatch: expected %h actual %h", r.acc, acc);
                errors++;
            end
            if (flags !== r.flags)
            begin
                $error("flags_out mismatch: expected %h actual %h", r.flags, flags);
                errors++;
            end
            if (q !== r.flags)
            begin
                $error("q_out mismatch: expected %h actual %h", r.flags, q);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] kind;
    logic [7:0] acc_in;
    logic [7:0] flags_in;
    logic [7:0] q_in;
    logic [7:0] operand;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] acc_out;
    logic [7:0] flags_out;
    logic [7:0] q_out;

    int unsigned idle_pct;
    int unsigned stall_pct;
    alu_scoreboard alu_sb;

    accumulator_flag_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .acc_in    (acc_in),
        .flags_in  (flags_in),
        .q_in      (q_in),
        .operand   (operand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .acc_out   (acc_out),
        .flags_out (flags_out),
        .q_out     (q_out)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 4'd0;
        acc_in = 8'h00;
        flags_in = 8'h00;
        q_in = 8'h00;
        operand = 8'h00;
        out_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        alu_sb = new();
    end

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            alu_sb.note_input(kind, acc_in, flags_in, q_in, operand);
        if (rst_n && out_valid && out_ready)
            alu_sb.check_output(acc_out, flags_out, q_out);
    end

    // End the run if no beat moves on either side for too long
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("accumulator_flag_alu test failed");
        $finish;
    end

    // Call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [3:0] k, input logic [7:0] a, input logic [7:0] f,
                             input logic [7:0] q, input logic [7:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        acc_in <= a;
        flags_in <= f;
        q_in <= q;
        operand <= d;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (alu_sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_random();
        logic [3:0] k;
        logic [7:0] a;
        logic [7:0] f;
        logic [7:0] q;
        int unsigned pick;
        if ($urandom_range(99) < 90)
            k = 4'($urandom_range(9));
        else
            k = 4'($urandom_range(15, 10));
        pick = $urandom_range(9);
        case (pick)
            0: a = 8'h00;
            1: a = 8'hFF;
            2: a = NEG_MIN;
            3: a = DAA_LIMIT;
            4: a = {4'($urandom_range(9)), 4'($urandom_range(9))};
            default: a = 8'($urandom);
        endcase
        f = 8'($urandom);
        pick = $urandom_range(3);
        if (pick == 0)
            q = 8'h00;
        else if (pick == 1)
            q = f;
        else
            q = 8'($urandom);
        send_beat(k, a, f, q, 8'($urandom));
    endtask

    initial
    begin
        #0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats, no idling on either side
        send_beat(KIND_DAA, 8'h9A, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_DAA, 8'h99, 8'h00, 8'h00, 8'hFF);
        send_beat(KIND_DAA, 8'h0F, FLAG_N, 8'h00, 8'h00);
        send_beat(KIND_DAA, 8'h00, FLAG_H | FLAG_C, 8'h00, 8'h00);
        send_beat(KIND_DAA, 8'hFF, FLAG_N | FLAG_H | FLAG_C, 8'hFF, 8'h00);
        send_beat(KIND_RLCA, 8'h80, 8'hFF, 8'h00, 8'h00);
        send_beat(KIND_RRCA, 8'h01, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_RLA, 8'h80, FLAG_C, 8'h00, 8'h00);
        send_beat(KIND_RRA, 8'h00, FLAG_C, 8'h00, 8'h00);
        send_beat(KIND_CPL, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_CPL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_beat(KIND_SCF, 8'h00, MASK_YX, 8'h00, 8'h00);
        send_beat(KIND_SCF, 8'h00, MASK_YX, MASK_YX, 8'h00);
        send_beat(KIND_CCF, 8'hFF, FLAG_C, 8'hFF, 8'h00);
        send_beat(KIND_NEG, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_NEG, NEG_MIN, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_NEG, 8'h01, 8'hFF, 8'h00, 8'h00);
        send_beat(KIND_NEG, 8'h10, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_CP, 8'h42, 8'h00, 8'h00, 8'h42);
        send_beat(KIND_CP, NEG_MIN, 8'h00, 8'h00, 8'h01);
        send_beat(KIND_CP, 8'h00, 8'h00, 8'h00, 8'h01);
        send_beat(KIND_CP, 8'h7F, 8'hFF, 8'h00, 8'hFF);
        send_beat(4'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_beat(4'd15, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random();
            wait_drained();
        end

        in_valid <= 1'b0;
        while (alu_sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (alu_sb.errors == 0)
            $display("accumulator_flag_alu test passed");
        else
            $display("accumulator_flag_alu test failed");
        $finish;
    end

endmodule
`default_nettype wire
